FILE: rtl/kt_pkg.sv
package kt_pkg;

  localparam int AXES          = 3;
  localparam int AXIS_W        = 2;
  localparam int AXIS_Z        = 2;
  localparam int CORDIC_STEPS  = 16;
  localparam int CORDIC_ITERS  = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int DIV_STEPS     = 17;
  localparam int STEP_W        = 5;

  localparam logic [31:0]        COV_INIT   = 32'd98304000;
  localparam logic signed [31:0] EST_Z_INIT = 32'sd256000;
  localparam logic [23:0]        Q_RST      = 24'd3276800;
  localparam logic [23:0]        RXY_RST    = 24'd655;
  localparam logic [23:0]        RZ_RST     = 24'd3277;
  localparam logic [63:0]        CALX_RST   = 64'd16384;
  localparam logic [63:0]        CALY_RST   = 64'd1073741824;
  localparam logic [63:0]        CALZ_RST   = 64'd70368744177664;
  localparam logic signed [24:0] ANG_QUART  = 25'sd2304000;
  localparam logic signed [17:0] ANG_MAX    = 18'sd18000;

  typedef enum logic [2:0] {
    CFG_PROC_NOISE = 3'd0,
    CFG_RXY        = 3'd1,
    CFG_RZ         = 3'd2,
    CFG_CAL_X      = 3'd3,
    CFG_CAL_Y      = 3'd4,
    CFG_CAL_Z      = 3'd5
  } kt_cfg_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PREP,
    OP_DIV,
    OP_MULE,
    OP_MULP,
    OP_UPD,
    OP_MAC,
    OP_CINIT,
    OP_CITER,
    OP_CDONE,
    OP_OUT
  } kt_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_MULE,
    S_MULP,
    S_UPD,
    S_MAC,
    S_CINIT,
    S_CITER,
    S_CDONE,
    S_OUT
  } kt_state_e;

  typedef struct packed {
    kt_op_e              op;
    logic [AXIS_W-1:0]   axis;
    logic [STEP_W-1:0]   step;
    logic                sel;
  } kt_cmd_t;

  // atan(2^-i) in 1/25600 degree
  function automatic logic [20:0] atan_tab(input logic [4:0] i);
    logic [20:0] v;
    unique case (i)
      5'd0:  v = 21'd1152000;
      5'd1:  v = 21'd680065;
      5'd2:  v = 21'd359328;
      5'd3:  v = 21'd182400;
      5'd4:  v = 21'd91554;
      5'd5:  v = 21'd45822;
      5'd6:  v = 21'd22916;
      5'd7:  v = 21'd11459;
      5'd8:  v = 21'd5730;
      5'd9:  v = 21'd2865;
      5'd10: v = 21'd1432;
      5'd11: v = 21'd716;
      5'd12: v = 21'd358;
      5'd13: v = 21'd179;
      5'd14: v = 21'd90;
      5'd15: v = 21'd45;
      5'd16: v = 21'd22;
      5'd17: v = 21'd11;
      5'd18: v = 21'd6;
      5'd19: v = 21'd3;
      5'd20: v = 21'd1;
      5'd21: v = 21'd1;
      default: v = 21'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/kt_ctrl.sv
module kt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output kt_pkg::kt_cmd_t  cmd_o
);

  localparam logic [kt_pkg::STEP_W-1:0] DIV_LAST = kt_pkg::STEP_W'(kt_pkg::DIV_STEPS - 1);
  localparam logic [kt_pkg::STEP_W-1:0] COR_LAST = kt_pkg::STEP_W'(kt_pkg::CORDIC_ITERS - 1);
  localparam logic [kt_pkg::AXIS_W-1:0] AX_LAST  = kt_pkg::AXIS_W'(kt_pkg::AXES - 1);
  localparam logic [kt_pkg::AXIS_W-1:0] ROW_LAST = kt_pkg::AXIS_W'(2);

  kt_pkg::kt_state_e state_q, state_d;
  logic [kt_pkg::AXIS_W-1:0] axis_q, axis_d;
  logic [kt_pkg::STEP_W-1:0] step_q, step_d;
  logic sel_q, sel_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kt_pkg::S_IDLE;
      axis_q      <= '0;
      step_q      <= '0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      step_q      <= step_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    step_d      = step_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o.op    = kt_pkg::OP_NONE;
    cmd_o.axis  = axis_q;
    cmd_o.step  = step_q;
    cmd_o.sel   = sel_q;
    unique case (state_q)
      kt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = kt_pkg::OP_LOAD;
          axis_d   = '0;
          state_d  = kt_pkg::S_PREP;
        end
      end
      kt_pkg::S_PREP: begin
        cmd_o.op = kt_pkg::OP_PREP;
        step_d   = '0;
        state_d  = kt_pkg::S_DIV;
      end
      kt_pkg::S_DIV: begin
        cmd_o.op = kt_pkg::OP_DIV;
        step_d   = step_q + 1'b1;
        if (step_q == DIV_LAST) begin
          state_d = kt_pkg::S_MULE;
        end
      end
      kt_pkg::S_MULE: begin
        cmd_o.op = kt_pkg::OP_MULE;
        state_d  = kt_pkg::S_MULP;
      end
      kt_pkg::S_MULP: begin
        cmd_o.op = kt_pkg::OP_MULP;
        state_d  = kt_pkg::S_UPD;
      end
      kt_pkg::S_UPD: begin
        cmd_o.op = kt_pkg::OP_UPD;
        if (axis_q == AX_LAST) begin
          axis_d  = '0;
          step_d  = '0;
          state_d = kt_pkg::S_MAC;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = kt_pkg::S_PREP;
        end
      end
      kt_pkg::S_MAC: begin
        cmd_o.op = kt_pkg::OP_MAC;
        step_d   = step_q + 1'b1;
        if (step_q == kt_pkg::STEP_W'(2)) begin
          step_d = '0;
          if (axis_q == ROW_LAST) begin
            sel_d   = 1'b0;
            state_d = kt_pkg::S_CINIT;
          end else begin
            axis_d = axis_q + 1'b1;
          end
        end
      end
      kt_pkg::S_CINIT: begin
        cmd_o.op = kt_pkg::OP_CINIT;
        step_d   = '0;
        state_d  = kt_pkg::S_CITER;
      end
      kt_pkg::S_CITER: begin
        cmd_o.op = kt_pkg::OP_CITER;
        step_d   = step_q + 1'b1;
        if (step_q == COR_LAST) begin
          state_d = kt_pkg::S_CDONE;
        end
      end
      kt_pkg::S_CDONE: begin
        cmd_o.op = kt_pkg::OP_CDONE;
        if (sel_q) begin
          state_d = kt_pkg::S_OUT;
        end else begin
          sel_d   = 1'b1;
          state_d = kt_pkg::S_CINIT;
        end
      end
      kt_pkg::S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = kt_pkg::OP_OUT;
          out_valid_d = 1'b1;
          state_d     = kt_pkg::S_IDLE;
        end
      end
      default: state_d = kt_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == kt_pkg::S_PREP && axis_q == '0))
    else $error("accepted beat did not start the filter");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kt_pkg::S_DIV) |-> (step_q <= DIV_LAST))
    else $error("divider step out of range");

  a_axis_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kt_pkg::S_PREP || state_q == kt_pkg::S_UPD) |-> (axis_q <= AX_LAST))
    else $error("axis index out of range");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == kt_pkg::OP_OUT) |=> (out_valid_q && state_q == kt_pkg::S_IDLE))
    else $error("result not presented");

endmodule

FILE: rtl/kt_dp.sv
module kt_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kt_pkg::kt_cmd_t     cmd_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [63:0]         cfg_data_i,
  input  logic signed [15:0]  accel_x_i,
  input  logic signed [15:0]  accel_y_i,
  input  logic signed [15:0]  accel_z_i,
  input  logic                restart_i,
  output logic signed [15:0]  filt_x_o,
  output logic signed [15:0]  filt_y_o,
  output logic signed [15:0]  filt_z_o,
  output logic signed [15:0]  cal_x_o,
  output logic signed [15:0]  cal_y_o,
  output logic signed [15:0]  cal_z_o,
  output logic signed [15:0]  pitch_angle_o,
  output logic signed [15:0]  roll_angle_o
);

  logic [23:0] q_q, rxy_q, rz_q;
  logic [63:0] cal_q [3];
  logic signed [31:0] est_q [3];
  logic [31:0] cov_q [3];
  logic signed [15:0] raw_q [3];
  logic signed [15:0] filt_q [3];
  logic signed [15:0] calv_q [3];
  logic signed [15:0] ang_q [2];

  logic [31:0] p1_q;
  logic [32:0] den_q;
  logic [33:0] rem_q;
  logic [16:0] k_q;
  logic signed [52:0] prod_q;
  logic signed [33:0] acc_q;
  logic signed [26:0] cx_q, cy_q;
  logic signed [24:0] cz_q;
  logic zero_q;

  logic [kt_pkg::AXIS_W-1:0] ax;
  logic [1:0] col;
  logic [32:0] psum;
  logic [31:0] p1;
  logic [23:0] rsel;
  logic [32:0] den;
  logic [33:0] trial;
  logic ge;
  logic [16:0] k_eff;
  logic signed [33:0] err;
  logic signed [17:0] mul_a;
  logic signed [34:0] mul_b;
  logic signed [52:0] mul_p;
  logic pneg;
  logic [52:0] pmag, pm;
  logic signed [52:0] rs, xn;
  logic signed [31:0] est_n;
  logic [52:0] csum;
  logic eneg;
  logic [32:0] emag, em;
  logic signed [25:0] fv;
  logic signed [15:0] filt_n;
  logic signed [15:0] gain, off;
  logic signed [33:0] base, acc_n;
  logic aneg;
  logic [33:0] amag, am;
  logic signed [20:0] cv;
  logic signed [15:0] cal_n;
  logic signed [15:0] cnum, cden;
  logic signed [26:0] x0, y0, xi, yi, dx, dy;
  logic signed [24:0] zi, tab;
  logic [4:0] sh;
  logic zneg;
  logic [24:0] zmag, zm;
  logic signed [17:0] zv;
  logic signed [15:0] ang_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q      <= kt_pkg::Q_RST;
      rxy_q    <= kt_pkg::RXY_RST;
      rz_q     <= kt_pkg::RZ_RST;
      cal_q[0] <= kt_pkg::CALX_RST;
      cal_q[1] <= kt_pkg::CALY_RST;
      cal_q[2] <= kt_pkg::CALZ_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kt_pkg::CFG_PROC_NOISE: q_q      <= cfg_data_i[23:0];
        kt_pkg::CFG_RXY:        rxy_q    <= cfg_data_i[23:0];
        kt_pkg::CFG_RZ:         rz_q     <= cfg_data_i[23:0];
        kt_pkg::CFG_CAL_X:      cal_q[0] <= cfg_data_i;
        kt_pkg::CFG_CAL_Y:      cal_q[1] <= cfg_data_i;
        kt_pkg::CFG_CAL_Z:      cal_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    ax    = cmd_i.axis;
    col   = cmd_i.step[1:0];
    // Kalman prep: saturated p + q, then denominator
    psum  = {1'b0, cov_q[ax]} + {9'd0, q_q};
    p1    = psum[32] ? '1 : psum[31:0];
    rsel  = (ax == kt_pkg::AXIS_W'(kt_pkg::AXIS_Z)) ? rz_q : rxy_q;
    den   = {1'b0, p1} + {9'd0, rsel};
    // restoring divider, one quotient bit per step
    trial = (cmd_i.step == '0) ? rem_q : {rem_q[32:0], 1'b0};
    ge    = (trial >= {1'b0, den_q});
    k_eff = (den_q == '0) ? '0 : k_q;
    err   = {{10{raw_q[ax][15]}}, raw_q[ax], 8'd0} - {{2{est_q[ax][31]}}, est_q[ax]};
    // shared multiplier
    gain  = cal_q[ax][{col, 4'd0} +: 16];
    off   = cal_q[ax][63:48];
    case (cmd_i.op)
      kt_pkg::OP_MULE: begin
        mul_a = {1'b0, k_eff};
        mul_b = {err[33], err};
      end
      kt_pkg::OP_MULP: begin
        mul_a = {1'b0, 17'd65536 - k_q};
        mul_b = {3'd0, p1_q};
      end
      default: begin
        mul_a = {{2{gain[15]}}, gain};
        mul_b = {{19{filt_q[col][15]}}, filt_q[col]};
      end
    endcase
    mul_p = mul_a * mul_b;
    // estimate update
    pneg  = prod_q[52];
    pmag  = pneg ? 53'(-prod_q) : 53'(prod_q);
    pm    = (pmag + 53'd32768) >> 16;
    rs    = pneg ? -$signed(pm) : $signed(pm);
    xn    = {{21{est_q[ax][31]}}, est_q[ax]} + rs;
    if (xn > 53'sd2147483647) begin
      est_n = 32'sh7FFFFFFF;
    end else if (xn < -53'sd2147483648) begin
      est_n = 32'sh80000000;
    end else begin
      est_n = xn[31:0];
    end
    csum  = 53'(prod_q) + 53'd32768;
    // filtered output, rounded to milli-g
    eneg  = est_q[ax][31];
    emag  = eneg ? {1'b0, 32'(-est_q[ax])} : {1'b0, 32'(est_q[ax])};
    em    = (emag + 33'd128) >> 8;
    fv    = eneg ? -$signed({1'b0, em[24:0]}) : $signed({1'b0, em[24:0]});
    if (fv > 26'sd32767) begin
      filt_n = 16'sh7FFF;
    end else if (fv < -26'sd32768) begin
      filt_n = 16'sh8000;
    end else begin
      filt_n = fv[15:0];
    end
    // calibration MAC
    base  = (col == 2'd0) ? {{8{off[15]}}, off, 10'd0} : acc_q;
    acc_n = base + mul_p[33:0];
    aneg  = acc_n[33];
    amag  = aneg ? 34'(-acc_n) : 34'(acc_n);
    am    = (amag + 34'd8192) >> 14;
    cv    = aneg ? -$signed({1'b0, am[19:0]}) : $signed({1'b0, am[19:0]});
    if (cv > 21'sd32767) begin
      cal_n = 16'sh7FFF;
    end else if (cv < -21'sd32768) begin
      cal_n = 16'sh8000;
    end else begin
      cal_n = cv[15:0];
    end
    // CORDIC
    cnum  = cmd_i.sel ? calv_q[1] : calv_q[0];
    cden  = calv_q[2];
    x0    = {{3{cden[15]}}, cden, 8'd0};
    y0    = {{3{cnum[15]}}, cnum, 8'd0};
    sh    = cmd_i.step;
    dx    = cy_q >>> sh;
    dy    = cx_q >>> sh;
    tab   = {4'd0, kt_pkg::atan_tab(sh)};
    if (cy_q > 27'sd0) begin
      xi = cx_q + dx;
      yi = cy_q - dy;
      zi = cz_q + tab;
    end else begin
      xi = cx_q - dx;
      yi = cy_q + dy;
      zi = cz_q - tab;
    end
    zneg  = cz_q[24];
    zmag  = zneg ? 25'(-cz_q) : 25'(cz_q);
    zm    = (zmag + 25'd128) >> 8;
    zv    = zneg ? -$signed({1'b0, zm[16:0]}) : $signed({1'b0, zm[16:0]});
    if (zero_q) begin
      ang_n = '0;
    end else if (zv > kt_pkg::ANG_MAX) begin
      ang_n = 16'(kt_pkg::ANG_MAX);
    end else if (zv < -kt_pkg::ANG_MAX) begin
      ang_n = 16'(-kt_pkg::ANG_MAX);
    end else begin
      ang_n = zv[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        est_q[a] <= (a == kt_pkg::AXIS_Z) ? kt_pkg::EST_Z_INIT : 32'sd0;
        cov_q[a] <= kt_pkg::COV_INIT;
      end
    end else begin
      case (cmd_i.op)
        kt_pkg::OP_LOAD: begin
          if (restart_i) begin
            for (int a = 0; a < 3; a++) begin
              est_q[a] <= (a == kt_pkg::AXIS_Z) ? kt_pkg::EST_Z_INIT : 32'sd0;
              cov_q[a] <= kt_pkg::COV_INIT;
            end
          end
        end
        kt_pkg::OP_MULP: est_q[ax] <= est_n;
        kt_pkg::OP_UPD:  cov_q[ax] <= csum[47:16];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      kt_pkg::OP_LOAD: begin
        raw_q[0]  <= accel_x_i;
        raw_q[1]  <= accel_y_i;
        raw_q[2]  <= accel_z_i;
        filt_q[0] <= accel_x_i;
        filt_q[1] <= accel_y_i;
        filt_q[2] <= accel_z_i;
      end
      kt_pkg::OP_PREP: begin
        p1_q  <= p1;
        den_q <= den;
        rem_q <= {2'd0, p1};
        k_q   <= '0;
      end
      kt_pkg::OP_DIV: begin
        rem_q <= ge ? (trial - {1'b0, den_q}) : trial;
        k_q   <= {k_q[15:0], ge};
      end
      kt_pkg::OP_MULE: begin
        k_q    <= k_eff;
        prod_q <= mul_p;
      end
      kt_pkg::OP_MULP: prod_q <= mul_p;
      kt_pkg::OP_UPD:  filt_q[ax] <= filt_n;
      kt_pkg::OP_MAC: begin
        acc_q <= acc_n;
        if (col == 2'd2) begin
          calv_q[ax] <= cal_n;
        end
      end
      kt_pkg::OP_CINIT: begin
        zero_q <= (cnum == '0) && (cden == '0);
        if (x0 < 27'sd0) begin
          if (y0 >= 27'sd0) begin
            cx_q <= y0;
            cy_q <= -x0;
            cz_q <= kt_pkg::ANG_QUART;
          end else begin
            cx_q <= -y0;
            cy_q <= x0;
            cz_q <= -kt_pkg::ANG_QUART;
          end
        end else begin
          cx_q <= x0;
          cy_q <= y0;
          cz_q <= '0;
        end
      end
      kt_pkg::OP_CITER: begin
        cx_q <= xi;
        cy_q <= yi;
        cz_q <= zi;
      end
      kt_pkg::OP_CDONE: ang_q[cmd_i.sel] <= ang_n;
      kt_pkg::OP_OUT: begin
        filt_x_o      <= filt_q[0];
        filt_y_o      <= filt_q[1];
        filt_z_o      <= filt_q[2];
        cal_x_o       <= calv_q[0];
        cal_y_o       <= calv_q[1];
        cal_z_o       <= calv_q[2];
        pitch_angle_o <= ang_q[0];
        roll_angle_o  <= ang_q[1];
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/accel_kalman_tilt_pipeline.sv
// Accelerometer tilt pipeline: per-axis scalar Kalman filter, 3x3 calibration
// with offset, pitch and roll by CORDIC atan2.
//
// Input channel (in_valid_i/in_ready_o) takes one beat of accel_x/y/z plus
// restart. Output channel (out_valid_o/out_ready_i) gives one result beat per
// input beat: filtered and calibrated vectors and the two angles.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i),
// written by the user only while the block is idle; not enforced in hardware.
//
// From input accept to out_valid_o the block works each axis in turn
// (prepare, 17-step restoring divider for the gain, gain-times-error and
// covariance products on the shared multiplier, update), then the
// calibration multiply-accumulate, then both angles on one CORDIC unit run
// twice, and the output load. One item is worked at a time; the next is
// accepted the cycle after the result is registered.
// The result sits in an output register; a stalled receiver only holds the
// block once a second result is finished. Reset loads the initial estimates
// and covariances and the default register values.
module accel_kalman_tilt_pipeline (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] filt_x_o,
  output logic signed [15:0] filt_y_o,
  output logic signed [15:0] filt_z_o,
  output logic signed [15:0] cal_x_o,
  output logic signed [15:0] cal_y_o,
  output logic signed [15:0] cal_z_o,
  output logic signed [15:0] pitch_angle_o,
  output logic signed [15:0] roll_angle_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i
);

  kt_pkg::kt_cmd_t cmd;

  kt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  kt_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .accel_x_i     (accel_x_i),
    .accel_y_i     (accel_y_i),
    .accel_z_i     (accel_z_i),
    .restart_i     (restart_i),
    .filt_x_o      (filt_x_o),
    .filt_y_o      (filt_y_o),
    .filt_z_o      (filt_z_o),
    .cal_x_o       (cal_x_o),
    .cal_y_o       (cal_y_o),
    .cal_z_o       (cal_z_o),
    .pitch_angle_o (pitch_angle_o),
    .roll_angle_o  (roll_angle_o)
  );

endmodule
